// File: hw/rtl/tof3_pkg.sv
// ----------------------------------------------------------------------------
// tof3_pkg
// Shared constants and types of the 3x3 outline filter.
// ----------------------------------------------------------------------------
package tof3_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int W_W            = 11;
    localparam int H_W            = 13;
    localparam int CNT_W          = 13;
    localparam int PIX_W          = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int FIFO_DEPTH     = 3;
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [W_W-1:0] WIDTH_RESET  = W_W'(320);
    localparam logic [H_W-1:0] HEIGHT_RESET = H_W'(200);

    localparam logic [PIX_W-1:0] MARK_VALUE    = 8'd255;
    localparam logic [PIX_W-1:0] OUTLINE_VALUE = 8'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             top_ok;
        logic             mid_ok;
        logic             emit;
        logic             oc_left;
        logic             oc_right;
        logic             last;
        logic             fwd;
    } t_s1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_result;

endpackage

// File: hw/rtl/tof3_ctrl.sv
// ----------------------------------------------------------------------------
// tof3_ctrl
// Configuration registers, frame position counters and pipeline fill.
// ----------------------------------------------------------------------------
module tof3_ctrl import tof3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_acc,
    input  logic                  i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic [COL_W-1:0]      o_rd_addr,
    output t_s1                   o_s1
);

    logic [W_W-1:0]   r_frame_width;
    logic [H_W-1:0]   r_frame_height;
    logic [COL_W-1:0] r_in_col;
    logic [H_W-1:0]   r_in_row;
    logic [COL_W-1:0] r_out_col;
    logic [H_W-1:0]   r_out_row;
    logic [CNT_W-1:0] r_fill;
    t_s1              r_s1;

    logic [CNT_W-1:0] w_eff;
    logic [H_W-1:0]   h_eff;
    logic [H_W:0]     h_x;
    logic [H_W:0]     row_x;
    logic [CNT_W-1:0] col_ext;
    logic [CNT_W-1:0] oc_ext;
    logic             in_frame;
    logic             emit;
    logic             out_wrap;
    logic             in_wrap;
    logic             last;
    logic [COL_W-1:0] n_in_col;
    logic [H_W-1:0]   n_in_row;
    logic [COL_W-1:0] n_out_col;
    logic [H_W-1:0]   n_out_row;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (CNT_W'(r_frame_width) > CNT_W'(MAX_LINE_WIDTH)) begin
            w_eff = CNT_W'(MAX_LINE_WIDTH);
        end else begin
            w_eff = CNT_W'(r_frame_width);
        end
        h_eff    = (r_frame_height == '0) ? H_W'(1) : r_frame_height;
        h_x      = (H_W+1)'(h_eff);
        row_x    = (H_W+1)'(r_in_row);
        col_ext  = CNT_W'(r_in_col);
        oc_ext   = CNT_W'(r_out_col);
        in_frame = row_x < h_x;
        emit     = r_fill >= (w_eff + CNT_W'(1));
        out_wrap = (oc_ext + CNT_W'(1)) >= w_eff;
        in_wrap  = (col_ext + CNT_W'(1)) >= w_eff;
        last     = ((H_W+1)'(r_out_row) + (H_W+1)'(1) >= h_x) && out_wrap;
        n_in_col  = in_wrap ? '0 : COL_W'(col_ext + CNT_W'(1));
        n_in_row  = in_wrap ? H_W'(r_in_row + H_W'(1)) : r_in_row;
        n_out_col = out_wrap ? '0 : COL_W'(oc_ext + CNT_W'(1));
        n_out_row = out_wrap ? H_W'(r_out_row + H_W'(1)) : r_out_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_fill         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= W_W'(i_cfg_wdata);
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= H_W'(i_cfg_wdata);
                end
                default: begin
                    r_frame_width <= r_frame_width;
                end
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_fill    <= '0;
        end else if (i_acc) begin
            if (emit && last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_fill    <= '0;
            end else begin
                if (emit) begin
                    r_out_col <= n_out_col;
                    r_out_row <= n_out_row;
                end else begin
                    r_fill <= r_fill + CNT_W'(1);
                end
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_acc;
        end
        if (i_acc) begin
            r_s1.col      <= r_in_col;
            r_s1.pix      <= (in_frame && i_cmd == CMD_PIXEL) ? i_pixel : '0;
            r_s1.top_ok   <= (row_x >= (H_W+1)'(2)) && (row_x < h_x + (H_W+1)'(2));
            r_s1.mid_ok   <= (row_x >= (H_W+1)'(1)) && (row_x < h_x + (H_W+1)'(1));
            r_s1.emit     <= emit;
            r_s1.oc_left  <= r_out_col != '0;
            r_s1.oc_right <= (oc_ext + CNT_W'(1)) < w_eff;
            r_s1.last     <= last;
            r_s1.fwd      <= r_s1.valid && (r_s1.col == r_in_col);
        end
    end

    assign o_rd_addr = r_in_col;
    assign o_s1      = r_s1;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff + CNT_W'(1))
        else $error("fill count beyond one line and one pixel");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && emit && last && !i_cfg_we
        |=> r_fill == '0 && r_in_col == '0 && r_in_row == '0 && r_out_row == '0)
        else $error("frame did not restart after its last output");

endmodule

// File: hw/rtl/tof3_line_buf.sv
// ----------------------------------------------------------------------------
// tof3_line_buf
// Two line memories holding the rows above the input row, with forwarding
// for a read that meets the write of the same column.
// ----------------------------------------------------------------------------
module tof3_line_buf import tof3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  t_s1              i_s1,
    output logic [PIX_W-1:0] o_up_raw,
    output logic [PIX_W-1:0] o_mid_raw
);

    logic [PIX_W-1:0] r_mem_up  [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] r_mem_mid [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] r_up_q;
    logic [PIX_W-1:0] r_mid_q;
    logic [PIX_W-1:0] r_fwd_up;
    logic [PIX_W-1:0] r_fwd_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q  <= r_mem_up[i_rd_addr];
            r_mid_q <= r_mem_mid[i_rd_addr];
        end
        if (i_s1.valid) begin
            r_mem_up[i_s1.col]  <= o_mid_raw;
            r_mem_mid[i_s1.col] <= i_s1.pix;
            r_fwd_up            <= o_mid_raw;
            r_fwd_mid           <= i_s1.pix;
        end
    end

    assign o_up_raw  = i_s1.fwd ? r_fwd_up  : r_up_q;
    assign o_mid_raw = i_s1.fwd ? r_fwd_mid : r_mid_q;

endmodule

// File: hw/rtl/tof3_window.sv
// ----------------------------------------------------------------------------
// tof3_window
// The 3x3 window columns and the outline decision for the center pixel.
// ----------------------------------------------------------------------------
module tof3_window import tof3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_s1              i_s1,
    input  logic [PIX_W-1:0] i_up_raw,
    input  logic [PIX_W-1:0] i_mid_raw,
    output logic             o_push,
    output t_result          o_result
);

    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             hit;

    always_comb begin
        top = i_s1.top_ok ? i_up_raw : '0;
        mid = i_s1.mid_ok ? i_mid_raw : '0;
        bot = i_s1.pix;
        hit = (r_win[3] == MARK_VALUE) || (r_win[5] == MARK_VALUE)
            || (i_s1.oc_left && ((r_win[0] == MARK_VALUE) || (r_win[1] == MARK_VALUE)
                || (r_win[2] == MARK_VALUE)))
            || (i_s1.oc_right && ((top == MARK_VALUE) || (mid == MARK_VALUE)
                || (bot == MARK_VALUE)));
        o_result.pixel_out = (r_win[4] == '0 && hit) ? OUTLINE_VALUE : r_win[4];
        o_result.frame_end = i_s1.last;
        o_push             = i_s1.valid && i_s1.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_s1.valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= bot;
        end
    end

endmodule

// File: hw/rtl/tof3_out_fifo.sv
// ----------------------------------------------------------------------------
// tof3_out_fifo
// Three-entry result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
module tof3_out_fifo import tof3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_inflight,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_full_stall
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   pop;
    logic [FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  n_rd_ptr;

    always_comb begin
        pop      = o_valid && !i_stall;
        n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                 : FIFO_PTR_W'(r_wr_ptr + FIFO_PTR_W'(1));
        n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                 : FIFO_PTR_W'(r_rd_ptr + FIFO_PTR_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    assign o_valid      = r_count != '0;
    assign o_result     = r_mem[r_rd_ptr];
    assign o_full_stall = ((FIFO_CNT_W+1)'(r_count) + (FIFO_CNT_W+1)'(i_inflight))
                          >= (FIFO_CNT_W+1)'(FIFO_DEPTH);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

// File: hw/rtl/text_outline_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// text_outline_filter_3x3_top
// Streaming 3x3 outline filter: a background pixel next to a marked pixel
// becomes the outline color; each pixel leaves one line and one pixel late.
//
//   channel   direction   handshake                 payload
//   in        to block    i_in_valid / o_in_stall   i_cmd, i_pixel
//   out       from block  o_out_valid / i_out_stall o_pixel_out, o_frame_end
//   cfg       to block    i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// One request is taken per clock while o_in_stall is low; the result it completes
// passes register s1 and the result queue and can be taken at the next edge.
// Each column costs one read and one write on each line memory per request.
// Reset clears counters, window and queue; the line memories need no clearing.
// o_in_stall rises when the queued results and the request in flight would fill
// the three-entry result queue, which an output stall can cause.
// ----------------------------------------------------------------------------
module text_outline_filter_3x3_top import tof3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_end
);

    logic             acc;
    logic [COL_W-1:0] rd_addr;
    t_s1              s1;
    logic [PIX_W-1:0] up_raw;
    logic [PIX_W-1:0] mid_raw;
    logic             push;
    t_result          result;
    t_result          out_result;

    assign acc = i_in_valid && !o_in_stall;

    tof3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .o_rd_addr   (rd_addr),
        .o_s1        (s1)
    );

    tof3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .i_s1      (s1),
        .o_up_raw  (up_raw),
        .o_mid_raw (mid_raw)
    );

    tof3_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_up_raw  (up_raw),
        .i_mid_raw (mid_raw),
        .o_push    (push),
        .o_result  (result)
    );

    tof3_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_result     (result),
        .i_inflight   (s1.valid),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_result     (out_result),
        .o_full_stall (o_in_stall)
    );

    assign o_pixel_out = out_result.pixel_out;
    assign o_frame_end = out_result.frame_end;

endmodule
